### hw/rtl/assert_macros.svh
// Assertion macros shared by the key press counter RTL.
// Expects clk and arst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// condition that must never be true
`define ASSERT_NEVER(lbl, cond, msg) \
	`ASSERT_CLK(lbl, !(cond), msg)

`endif

### hw/rtl/kpc_pkg.sv
// Package for the key press counter: opcodes, register indexes, sequencer types.
// No dependencies.
package kpc_pkg;

	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 7;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t REG_PAUSED = cfg_idx_t'(0);
	localparam cfg_idx_t REG_SHARED_KEY = cfg_idx_t'(1);

	typedef enum logic [2:0] {
		OP_MAKE = 3'd0,
		OP_BREAK = 3'd1,
		OP_REL_DEV = 3'd2,
		OP_REL_KEY = 3'd3,
		OP_CLR_CNT = 3'd4,
		OP_CLR_ALL = 3'd5,
		OP_READ = 3'd6
	} opcode_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CALC,
		S_SWP_RD,
		S_SWP_WR,
		S_DONE
	} state_t;

	typedef struct packed {
		logic in_ready;
		logic calc_fire;
		logic sweep_start;
		logic sw_rd;
		logic sw_wr;
		logic done_fire;
	} ctrl_t;

	typedef struct packed {
		logic in_fire;
		logic slot_free;
		logic sweep_go;
		logic sweep_last;
	} stat_t;

endpackage

### hw/rtl/kpc_ram.sv
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module kpc_ram #(
	parameter int WIDTH = 40,
	parameter int DEPTH = 128,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

### hw/rtl/kpc_seq.sv
// Sequencer for the key press counter: accept, read-modify-write, device sweep.
// Depends on kpc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module kpc_seq (
	input  logic           clk,
	input  logic           arst_n,
	input  kpc_pkg::stat_t stat,
	output kpc_pkg::ctrl_t ctrl
);

	kpc_pkg::state_t state_q;
	kpc_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= kpc_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			kpc_pkg::S_IDLE: begin
				if (stat.in_fire) state_d = kpc_pkg::S_CALC;
			end
			kpc_pkg::S_CALC: begin
				if (stat.slot_free) begin
					state_d = stat.sweep_go ? kpc_pkg::S_SWP_RD : kpc_pkg::S_IDLE;
				end
			end
			kpc_pkg::S_SWP_RD: begin
				state_d = kpc_pkg::S_SWP_WR;
			end
			kpc_pkg::S_SWP_WR: begin
				state_d = stat.sweep_last ? kpc_pkg::S_DONE : kpc_pkg::S_SWP_RD;
			end
			kpc_pkg::S_DONE: begin
				if (stat.slot_free) state_d = kpc_pkg::S_IDLE;
			end
			default: begin
				state_d = kpc_pkg::S_IDLE;
			end
		endcase
	end

	always_comb begin
		ctrl = '0;
		unique case (state_q)
			kpc_pkg::S_IDLE: begin
				ctrl.in_ready = 1'b1;
			end
			kpc_pkg::S_CALC: begin
				ctrl.calc_fire = stat.slot_free;
				ctrl.sweep_start = stat.slot_free && stat.sweep_go;
			end
			kpc_pkg::S_SWP_RD: begin
				ctrl.sw_rd = 1'b1;
			end
			kpc_pkg::S_SWP_WR: begin
				ctrl.sw_wr = 1'b1;
			end
			kpc_pkg::S_DONE: begin
				ctrl.done_fire = stat.slot_free;
			end
			default: begin
				ctrl = '0;
			end
		endcase
	end

	`ASSERT_CLK(a_fire_to_calc, stat.in_fire |=> state_q == kpc_pkg::S_CALC, "accepted transaction did not reach calc")
	`ASSERT_CLK(a_wr_after_rd, ctrl.sw_wr |-> $past(ctrl.sw_rd), "sweep write without preceding read")

endmodule

### hw/rtl/key_press_counter_repeat_filter_unit.sv
// Key press counter with auto-repeat filter: key, clear and read operations are computed
// from the accepted transaction and its RAM row, and the result is registered once the
// output slot is free; release device first runs a read-modify-write sweep over the RAM.
// Not ready while a transaction is busy, so a new one is taken only after the last result.
// Reset clears configuration, total and the per-key valid flags that shadow the RAM.
// Depends on kpc_pkg, kpc_ram, kpc_seq and assert_macros.svh.
`include "assert_macros.svh"

module key_press_counter_repeat_filter_unit #(
	parameter int KEY_COUNT = 128,
	parameter int DEVICES = 8,
	parameter int COUNT_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [2:0]                    opcode,
	input  logic [2:0]                    device,
	input  logic [7:0]                    key,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          recognized,
	output logic                          counted,
	output logic [31:0]                   key_count,
	output logic [31:0]                   sum_count,
	output logic                          key_held,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [kpc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [kpc_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int AW = $clog2(KEY_COUNT);
	localparam int W = DEVICES + COUNT_WIDTH;
	localparam int XW = (COUNT_WIDTH > 32) ? COUNT_WIDTH : 32;

	function automatic logic [31:0] to_f32(input logic [COUNT_WIDTH-1:0] v);
		logic [XW-1:0] e;
		e = XW'(v);
		to_f32 = (e > XW'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : e[31:0];
	endfunction

	function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
		sat_inc = (&v) ? v : v + COUNT_WIDTH'(1);
	endfunction

	kpc_pkg::ctrl_t ctrl;
	kpc_pkg::stat_t stat;

	logic in_fire;
	logic slot_free;
	logic emit;

	logic paused_q;
	logic [6:0] shared_q;

	kpc_pkg::opcode_t op_q;
	logic [2:0] dev_q;
	logic [7:0] key_q;
	logic [AW-1:0] idx_q;
	logic [COUNT_WIDTH-1:0] total_q;
	logic [KEY_COUNT-1:0] held_vld_q;
	logic [KEY_COUNT-1:0] cnt_vld_q;

	logic out_valid_q;
	logic recognized_q;
	logic counted_q;
	logic [31:0] key_count_q;
	logic [31:0] sum_count_q;
	logic key_held_q;

	logic ram_wr_en;
	logic ram_rd_en;
	logic [AW-1:0] ram_rd_addr;
	logic [AW-1:0] cur_addr;
	logic [W-1:0] ram_wr_data;
	logic [W-1:0] ram_rd_data;

	logic key_op;
	logic valid;
	logic [2:0] tdev;
	logic tdev_ok;
	logic dev_ok;
	logic [DEVICES-1:0] tmask;
	logic [DEVICES-1:0] dmask;
	logic [DEVICES-1:0] row_old;
	logic [DEVICES-1:0] row_new;
	logic [DEVICES-1:0] sweep_row;
	logic [COUNT_WIDTH-1:0] cnt_old;
	logic [COUNT_WIDTH-1:0] cnt_new;
	logic [COUNT_WIDTH-1:0] tot_new;
	logic was;
	logic cnt_hit;

	kpc_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctrl   (ctrl)
	);

	kpc_ram #(
		.WIDTH (W),
		.DEPTH (KEY_COUNT)
	) u_ram (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (cur_addr),
		.wr_data (ram_wr_data),
		.rd_en   (ram_rd_en),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

	assign in_ready = ctrl.in_ready;
	assign in_fire = in_valid && ctrl.in_ready;
	assign slot_free = !out_valid_q || out_ready;
	assign cfg_ready = 1'b1;

	assign stat.in_fire = in_fire;
	assign stat.slot_free = slot_free;
	assign stat.sweep_go = (op_q == kpc_pkg::OP_REL_DEV) && dev_ok;
	assign stat.sweep_last = (idx_q == AW'(KEY_COUNT - 1));

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			paused_q <= 1'b0;
			shared_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				kpc_pkg::REG_PAUSED: paused_q <= cfg_data[0];
				kpc_pkg::REG_SHARED_KEY: shared_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_q <= kpc_pkg::opcode_t'(opcode);
			dev_q <= device;
			key_q <= key;
		end
	end

	always_comb begin
		case (op_q) inside
			kpc_pkg::OP_MAKE, kpc_pkg::OP_BREAK, kpc_pkg::OP_REL_KEY, kpc_pkg::OP_READ:
				key_op = 1'b1;
			default:
				key_op = 1'b0;
		endcase
	end

	assign valid = key_op && ({1'b0, key_q} < 9'(KEY_COUNT));
	assign tdev = (key_q == {1'b0, shared_q}) ? 3'd0 : dev_q;
	assign tdev_ok = ({4'b0, tdev} < 7'(DEVICES));
	assign dev_ok = ({4'b0, dev_q} < 7'(DEVICES));
	assign tmask = DEVICES'(1) << tdev;
	assign dmask = DEVICES'(1) << dev_q;

	assign cur_addr = ctrl.sw_wr ? idx_q : key_q[AW-1:0];
	assign ram_rd_en = in_fire || ctrl.sw_rd;
	assign ram_rd_addr = ctrl.in_ready ? key[AW-1:0] : idx_q;

	assign row_old = held_vld_q[cur_addr] ? ram_rd_data[W-1:COUNT_WIDTH] : '0;
	assign cnt_old = cnt_vld_q[cur_addr] ? ram_rd_data[COUNT_WIDTH-1:0] : '0;
	assign was = |(row_old & tmask);
	assign sweep_row = row_old & ~dmask;

	always_comb begin
		row_new = row_old;
		cnt_new = cnt_old;
		tot_new = total_q;
		cnt_hit = 1'b0;
		if (valid) begin
			case (op_q)
				kpc_pkg::OP_MAKE: begin
					if (tdev_ok) begin
						row_new = row_old | tmask;
						if (!was && !paused_q) begin
							cnt_new = sat_inc(cnt_old);
							tot_new = sat_inc(total_q);
							cnt_hit = 1'b1;
						end
					end
				end
				kpc_pkg::OP_BREAK: begin
					if (tdev_ok) row_new = row_old & ~tmask;
				end
				kpc_pkg::OP_REL_KEY: begin
					row_new = '0;
				end
				default: ;
			endcase
		end
		if (op_q == kpc_pkg::OP_CLR_CNT || op_q == kpc_pkg::OP_CLR_ALL) begin
			tot_new = '0;
		end
	end

	assign ram_wr_en = (ctrl.calc_fire && valid) || ctrl.sw_wr;
	assign ram_wr_data = ctrl.sw_wr ? {sweep_row, cnt_old} : {row_new, cnt_new};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			held_vld_q <= '0;
			cnt_vld_q <= '0;
			idx_q <= '0;
		end else begin
			if (ctrl.calc_fire) begin
				total_q <= tot_new;
			end
			if (ctrl.calc_fire && op_q == kpc_pkg::OP_CLR_CNT) begin
				cnt_vld_q <= '0;
			end else if (ctrl.calc_fire && op_q == kpc_pkg::OP_CLR_ALL) begin
				cnt_vld_q <= '0;
				held_vld_q <= '0;
			end else if (ram_wr_en) begin
				cnt_vld_q[cur_addr] <= 1'b1;
				held_vld_q[cur_addr] <= 1'b1;
			end
			if (ctrl.sweep_start) begin
				idx_q <= '0;
			end else if (ctrl.sw_wr && !stat.sweep_last) begin
				idx_q <= idx_q + AW'(1);
			end
		end
	end

	// result register
	assign emit = (ctrl.calc_fire && !stat.sweep_go) || ctrl.done_fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			recognized_q <= valid;
			counted_q <= cnt_hit;
			key_count_q <= valid ? to_f32(cnt_new) : 32'd0;
			sum_count_q <= to_f32(tot_new);
			key_held_q <= valid && (|row_new);
		end
	end

	assign out_valid = out_valid_q;
	assign recognized = recognized_q;
	assign counted = counted_q;
	assign key_count = key_count_q;
	assign sum_count = sum_count_q;
	assign key_held = key_held_q;

	`ASSERT_NEVER(a_no_wr_idle, ram_wr_en && ctrl.in_ready, "RAM written while idle")
	`ASSERT_NEVER(a_emit_slot, emit && out_valid_q && !out_ready, "result overwrote pending transaction")

endmodule

### test/tb_key_press_counter_repeat_filter_unit.sv
// Testbench for key_press_counter_repeat_filter_unit: queued key events, a behavioural
// predictor of held bits and press counters, and a result scoreboard checked per field.
// Depends on kpc_pkg and the RTL of the counter unit.
`timescale 1ns / 100ps

module tb_key_press_counter_repeat_filter_unit;

	localparam int KEYS = 128;
	localparam int DEVS = 8;
	localparam logic [2:0] OP_NONE = 3'd7;
	localparam kpc_pkg::cfg_idx_t REG_SPARE = kpc_pkg::cfg_idx_t'(3);
	localparam int SETTLE_CYCLES = 2 * KEYS + 4;
	localparam int CYCLE_LIMIT = 2000000;
	localparam int PHASE_EVENTS = 280;
	localparam int HOLD_OFF_CYCLES = 400;

	typedef struct packed {
		logic [2:0] op;
		logic [2:0] dev;
		logic [7:0] key;
	} key_event_t;

	typedef struct packed {
		logic        recognized;
		logic        counted;
		logic [31:0] key_count;
		logic [31:0] sum_count;
		logic        key_held;
	} key_result_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [2:0] opcode;
	logic [2:0] device;
	logic [7:0] key;
	logic out_valid;
	logic out_ready;
	logic recognized;
	logic counted;
	logic [31:0] key_count;
	logic [31:0] sum_count;
	logic key_held;
	logic cfg_valid;
	logic cfg_ready;
	kpc_pkg::cfg_idx_t cfg_index;
	logic [kpc_pkg::CFG_DATA_W-1:0] cfg_data;

	key_event_t pending_events[$];
	key_result_t expected_results[$];

	logic [KEYS-1:0] held_map [DEVS];
	logic [31:0] press_counts [KEYS];
	logic [31:0] press_total;
	logic count_paused;
	logic [6:0] shared_sel;

	logic [7:0] hot_keys [6];
	int send_idle_pct;
	int recv_idle_pct;
	int error_count;
	int cycle_count;
	int sent_count;
	int accept_count;
	bit hold_off_request;
	bit receiver_held;

	key_press_counter_repeat_filter_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.opcode(opcode),
		.device(device),
		.key(key),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.recognized(recognized),
		.counted(counted),
		.key_count(key_count),
		.sum_count(sum_count),
		.key_held(key_held),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic logic [31:0] bump_count(input logic [31:0] c);
		return (c == '1) ? c : c + 32'd1;
	endfunction

	task automatic compute_key_result(input key_event_t ev, output key_result_t res);
		logic known;
		logic [6:0] k;
		logic [2:0] slot;
		res = '0;
		k = ev.key[6:0];
		known = (ev.op == kpc_pkg::OP_MAKE || ev.op == kpc_pkg::OP_BREAK ||
			ev.op == kpc_pkg::OP_REL_KEY || ev.op == kpc_pkg::OP_READ) &&
			ev.key < 8'(KEYS);
		if (known) begin
			slot = (k == shared_sel) ? 3'd0 : ev.dev;
			if (ev.op == kpc_pkg::OP_MAKE) begin
				if (!held_map[slot][k] && !count_paused) begin
					press_counts[k] = bump_count(press_counts[k]);
					press_total = bump_count(press_total);
					res.counted = 1'b1;
				end
				held_map[slot][k] = 1'b1;
			end else if (ev.op == kpc_pkg::OP_BREAK) begin
				held_map[slot][k] = 1'b0;
			end else if (ev.op == kpc_pkg::OP_REL_KEY) begin
				for (int d = 0; d < DEVS; d++)
					held_map[d][k] = 1'b0;
			end
		end else if (ev.op == kpc_pkg::OP_REL_DEV) begin
			held_map[ev.dev] = '0;
		end else if (ev.op == kpc_pkg::OP_CLR_CNT || ev.op == kpc_pkg::OP_CLR_ALL) begin
			for (int i = 0; i < KEYS; i++)
				press_counts[i] = '0;
			press_total = '0;
			if (ev.op == kpc_pkg::OP_CLR_ALL)
				for (int d = 0; d < DEVS; d++)
					held_map[d] = '0;
		end
		res.recognized = known;
		res.key_count = known ? press_counts[k] : 32'd0;
		res.sum_count = press_total;
		if (known)
			for (int d = 0; d < DEVS; d++)
				if (held_map[d][k])
					res.key_held = 1'b1;
	endtask

	task automatic report_mismatch(input string field, input logic [31:0] got,
		input logic [31:0] want);
		$display("mismatch at cycle %0d: %s got %0h, expected %0h", cycle_count, field,
			got, want);
		error_count++;
	endtask

	// driver: hold the payload until the transaction is accepted
	always @(negedge clk) begin
		key_event_t ev;
		if (!arst_n) begin
			in_valid <= 1'b0;
			opcode <= '0;
			device <= '0;
			key <= '0;
			sent_count = 0;
		end else if (!in_valid || accept_count == sent_count) begin
			if (pending_events.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				ev = pending_events.pop_front();
				opcode <= ev.op;
				device <= ev.dev;
				key <= ev.key;
				in_valid <= 1'b1;
				sent_count++;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (!arst_n)
			out_ready <= 1'b0;
		else
			out_ready <= !receiver_held && $urandom_range(99) >= recv_idle_pct;
	end

	initial begin : receiver_hold_off
		receiver_held = 1'b0;
		wait (hold_off_request);
		@(posedge clk);
		receiver_held = 1'b1;
		for (int n = 0; n < HOLD_OFF_CYCLES; n++)
			@(posedge clk);
		receiver_held = 1'b0;
	end

	// monitor: check results first, then predict the accepted transaction
	always @(posedge clk) begin
		key_result_t want;
		key_result_t got;
		key_event_t seen;
		if (!arst_n) begin
			for (int d = 0; d < DEVS; d++)
				held_map[d] = '0;
			for (int i = 0; i < KEYS; i++)
				press_counts[i] = '0;
			press_total = '0;
			count_paused = 1'b0;
			shared_sel = '0;
			error_count = 0;
			accept_count = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == kpc_pkg::REG_PAUSED)
					count_paused = cfg_data[0];
				else if (cfg_index == kpc_pkg::REG_SHARED_KEY)
					shared_sel = cfg_data[6:0];
			end
			if (out_valid && out_ready) begin
				got = '{recognized, counted, key_count, sum_count, key_held};
				if (expected_results.size() == 0) begin
					report_mismatch("unexpected result", got.sum_count, 32'd0);
				end else begin
					want = expected_results.pop_front();
					if (got.recognized !== want.recognized)
						report_mismatch("recognized", 32'(got.recognized),
							32'(want.recognized));
					if (got.counted !== want.counted)
						report_mismatch("counted", 32'(got.counted), 32'(want.counted));
					if (got.key_count !== want.key_count)
						report_mismatch("key_count", got.key_count, want.key_count);
					if (got.sum_count !== want.sum_count)
						report_mismatch("sum_count", got.sum_count, want.sum_count);
					if (got.key_held !== want.key_held)
						report_mismatch("key_held", 32'(got.key_held), 32'(want.key_held));
				end
			end
			if (in_valid && in_ready) begin
				seen = {opcode, device, key};
				compute_key_result(seen, want);
				expected_results.push_back(want);
				accept_count++;
			end
		end
	end

	initial begin : watchdog
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb_key_press_counter_repeat_filter_unit: done, errors");
		$finish;
	end

	task automatic queue_event(input logic [2:0] op, input logic [2:0] dev,
		input logic [7:0] k);
		key_event_t ev;
		ev = {op, dev, k};
		pending_events.push_back(ev);
	endtask

	task automatic write_register(input kpc_pkg::cfg_idx_t idx,
		input logic [kpc_pkg::CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic wait_drained;
		while (pending_events.size() != 0 || in_valid || expected_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic key_event_t random_event;
		key_event_t ev;
		int r;
		r = $urandom_range(99);
		if (r < 36)
			ev.op = kpc_pkg::OP_MAKE;
		else if (r < 62)
			ev.op = kpc_pkg::OP_BREAK;
		else if (r < 81)
			ev.op = kpc_pkg::OP_READ;
		else if (r < 88)
			ev.op = kpc_pkg::OP_REL_KEY;
		else if (r < 91)
			ev.op = kpc_pkg::OP_REL_DEV;
		else if (r < 93)
			ev.op = kpc_pkg::OP_CLR_CNT;
		else if (r < 94)
			ev.op = kpc_pkg::OP_CLR_ALL;
		else if (r < 96)
			ev.op = OP_NONE;
		else
			ev.op = 3'($urandom_range(7));
		ev.dev = 3'($urandom_range(DEVS - 1));
		r = $urandom_range(99);
		if (r < 60)
			ev.key = hot_keys[$urandom_range(5)];
		else if (r < 72)
			ev.key = {1'b0, shared_sel};
		else if (r < 88)
			ev.key = 8'($urandom_range(KEYS - 1));
		else if (r < 96)
			ev.key = 8'($urandom_range(255, KEYS));
		else
			ev.key = (r < 98) ? 8'(r[0] ? KEYS - 1 : 0) : 8'(r[0] ? 255 : KEYS);
		return ev;
	endfunction

	initial begin : stimulus
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		hold_off_request = 1'b0;
		send_idle_pct = 21;
		recv_idle_pct = 80;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		write_register(kpc_pkg::REG_PAUSED, '0);
		write_register(kpc_pkg::REG_SHARED_KEY, '0);
		queue_event(kpc_pkg::OP_READ, 3'd0, 8'd0);
		queue_event(kpc_pkg::OP_MAKE, 3'd0, 8'd0);
		queue_event(kpc_pkg::OP_MAKE, 3'd5, 8'd0);
		queue_event(kpc_pkg::OP_MAKE, 3'd7, 8'd127);
		queue_event(kpc_pkg::OP_MAKE, 3'd7, 8'd127);
		queue_event(kpc_pkg::OP_MAKE, 3'd3, 8'd127);
		queue_event(kpc_pkg::OP_BREAK, 3'd7, 8'd127);
		queue_event(kpc_pkg::OP_READ, 3'd4, 8'd127);
		queue_event(kpc_pkg::OP_MAKE, 3'd0, 8'd128);
		queue_event(kpc_pkg::OP_READ, 3'd7, 8'd255);
		queue_event(kpc_pkg::OP_BREAK, 3'd2, 8'd200);
		queue_event(kpc_pkg::OP_REL_KEY, 3'd1, 8'd255);
		queue_event(kpc_pkg::OP_REL_KEY, 3'd6, 8'd127);
		queue_event(kpc_pkg::OP_READ, 3'd0, 8'd127);
		queue_event(kpc_pkg::OP_MAKE, 3'd2, 8'd64);
		queue_event(kpc_pkg::OP_MAKE, 3'd2, 8'd65);
		queue_event(kpc_pkg::OP_REL_DEV, 3'd2, 8'd255);
		queue_event(kpc_pkg::OP_READ, 3'd0, 8'd64);
		queue_event(kpc_pkg::OP_MAKE, 3'd2, 8'd64);
		queue_event(OP_NONE, 3'd7, 8'd255);
		queue_event(kpc_pkg::OP_CLR_CNT, 3'd0, 8'd0);
		queue_event(kpc_pkg::OP_MAKE, 3'd1, 8'd1);
		queue_event(kpc_pkg::OP_CLR_ALL, 3'd5, 8'd170);
		queue_event(kpc_pkg::OP_READ, 3'd1, 8'd1);
		queue_event(kpc_pkg::OP_BREAK, 3'd0, 8'd0);
		wait_drained();

		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: begin
					write_register(kpc_pkg::REG_SHARED_KEY, 7'd127);
				end
				1: begin
					write_register(kpc_pkg::REG_PAUSED, 7'd1);
					write_register(kpc_pkg::REG_SHARED_KEY, 7'($urandom_range(KEYS - 1)));
				end
				2: begin
					write_register(kpc_pkg::REG_PAUSED, 7'($urandom_range(127) & 7'h7e));
					write_register(kpc_pkg::REG_SHARED_KEY, 7'($urandom_range(KEYS - 1)));
				end
				3: begin
					write_register(REG_SPARE, 7'($urandom_range(127)));
					write_register(kpc_pkg::REG_PAUSED, 7'h7f);
					write_register(kpc_pkg::REG_SHARED_KEY, '0);
				end
				4: begin
					write_register(kpc_pkg::REG_PAUSED, '0);
					write_register(kpc_pkg::REG_SHARED_KEY, 7'($urandom_range(KEYS - 1)));
				end
				default: begin
					write_register(kpc_pkg::REG_SHARED_KEY, 7'd127);
				end
			endcase
			send_idle_pct = (phase < 2) ? 21 : (phase < 4) ? 80 : 0;
			recv_idle_pct = (phase < 2) ? 80 : (phase < 4) ? 21 : 0;
			for (int h = 0; h < 6; h++)
				hot_keys[h] = 8'($urandom_range(KEYS - 1));
			for (int n = 0; n < PHASE_EVENTS; n++)
				pending_events.push_back(random_event());
			if (phase == 4)
				hold_off_request = 1'b1;
			wait_drained();
		end

		if (error_count == 0)
			$display("tb_key_press_counter_repeat_filter_unit: done, clean");
		else
			$display("tb_key_press_counter_repeat_filter_unit: done, errors");
		$finish;
	end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/kpc_pkg.sv
hw/rtl/kpc_ram.sv
hw/rtl/kpc_seq.sv
hw/rtl/key_press_counter_repeat_filter_unit.sv
test/tb_key_press_counter_repeat_filter_unit.sv
